// ===== src/cafc_pkg.sv =====
// Shared types, widths and codes for the cryostat autofill controller.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package cafc_pkg;

    // Sensor and timer widths
    localparam int SENSOR_BITS = 16;
    localparam int TIMER_BITS  = 16;

    // Configuration write data carries the widest register
    localparam int CFG_DATA_BITS = (SENSOR_BITS > TIMER_BITS) ? SENSOR_BITS : TIMER_BITS;
    localparam int CFG_IDX_BITS  = 2;

    // Result mode code width
    localparam int MODE_BITS = 3;

    // Stream payload widths, rounded up to whole bytes
    localparam int S_FIELD_BITS = 2 * SENSOR_BITS + 2;
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = MODE_BITS + 1 + TIMER_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    // Saturation value of the fill counter
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_EMPTY_TEMP_THRESHOLD = 2'd0,
        CFG_PRESSURE_LIMIT       = 2'd1,
        CFG_FILL_TIME_LIMIT      = 2'd2
    } cfg_idx_t;

    // Item kinds carried on s_tuser
    localparam logic CMD_SENSOR = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Mode codes as reported on the result stream
    localparam logic [MODE_BITS-1:0] MODE_INITIAL          = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_EMPTY            = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_FULL             = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_FILLING          = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_SUPPLY_EMPTY     = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_SUPPLY_REFILLED  = 3'd5;

    // Controller state, one-hot
    typedef enum logic [5:0] {
        ST_INITIAL         = 6'b000001,
        ST_EMPTY           = 6'b000010,
        ST_FULL            = 6'b000100,
        ST_FILLING         = 6'b001000,
        ST_SUPPLY_EMPTY    = 6'b010000,
        ST_SUPPLY_REFILLED = 6'b100000
    } state_t;

    // Configuration register set
    typedef struct packed {
        logic [SENSOR_BITS-1:0] empty_temp_threshold;
        logic [SENSOR_BITS-1:0] pressure_limit;
        logic [TIMER_BITS-1:0]  fill_time_limit;
    } cfg_t;

    // One input item
    typedef struct packed {
        logic                   cmd;
        logic [SENSOR_BITS-1:0] tank_temperature;
        logic [SENSOR_BITS-1:0] vessel_pressure;
        logic                   autofill_on;
        logic                   supply_refilled;
    } item_t;

    // One result item
    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic                  mode_changed;
        logic [TIMER_BITS-1:0] fill_ticks;
    } result_t;

    // Map a state to its reported mode code
    function automatic logic [MODE_BITS-1:0] mode_code(input state_t st);
        logic [MODE_BITS-1:0] code;
        code = MODE_INITIAL;
        unique case (st)
            ST_INITIAL:         code = MODE_INITIAL;
            ST_EMPTY:           code = MODE_EMPTY;
            ST_FULL:            code = MODE_FULL;
            ST_FILLING:         code = MODE_FILLING;
            ST_SUPPLY_EMPTY:    code = MODE_SUPPLY_EMPTY;
            ST_SUPPLY_REFILLED: code = MODE_SUPPLY_REFILLED;
            default:            code = MODE_INITIAL;
        endcase
        return code;
    endfunction

endpackage

// ===== src/cafc_cfg_regs.sv =====
// Configuration register file for the autofill controller.
// Depends on cafc_pkg for widths, register indexes and cfg_t.
`timescale 1ns / 1ps

module cafc_cfg_regs
    import cafc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [CFG_IDX_BITS-1:0]  wr_index,
    input  logic [CFG_DATA_BITS-1:0] wr_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes leave everything alone
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_EMPTY_TEMP_THRESHOLD:
                    cfg_next.empty_temp_threshold = wr_data[SENSOR_BITS-1:0];
                CFG_PRESSURE_LIMIT:
                    cfg_next.pressure_limit = wr_data[SENSOR_BITS-1:0];
                CFG_FILL_TIME_LIMIT:
                    cfg_next.fill_time_limit = wr_data[TIMER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/cafc_fsm.sv =====
// Autofill state machine and saturating fill-tick counter.
// Depends on cafc_pkg for state_t, item_t, cfg_t and result_t.
`timescale 1ns / 1ps

module cafc_fsm
    import cafc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    state_t                state_reg;
    state_t                state_next;
    logic [TIMER_BITS-1:0] fill_cnt_reg;
    logic [TIMER_BITS-1:0] fill_cnt_next;
    logic                  temp_below;
    logic                  refill_ok;
    logic                  changed;

    // Threshold and refill qualification
    assign temp_below = item.tank_temperature < cfg.empty_temp_threshold;
    assign refill_ok  = !temp_below && item.autofill_on
                        && (item.vessel_pressure < cfg.pressure_limit);

    // Next state: ticks never move the state
    always_comb begin
        state_next = state_reg;
        if (item.cmd == CMD_SENSOR) begin
            unique case (state_reg) inside
                ST_EMPTY, ST_SUPPLY_REFILLED: begin
                    if (refill_ok) state_next = ST_FILLING;
                end
                ST_FULL: begin
                    if (item.tank_temperature > cfg.empty_temp_threshold)
                        state_next = ST_EMPTY;
                end
                ST_FILLING: begin
                    if (fill_cnt_reg > cfg.fill_time_limit)
                        state_next = temp_below ? ST_FULL : ST_SUPPLY_EMPTY;
                end
                ST_SUPPLY_EMPTY: begin
                    if (item.supply_refilled) state_next = ST_SUPPLY_REFILLED;
                end
                default: begin
                    if (temp_below)     state_next = ST_FULL;
                    else if (refill_ok) state_next = ST_FILLING;
                    else                state_next = ST_EMPTY;
                end
            endcase
        end
    end

    assign changed = state_next != state_reg;

    // Counter: clear on entry to filling, saturate on ticks while filling
    always_comb begin
        fill_cnt_next = fill_cnt_reg;
        if (changed && state_next == ST_FILLING) begin
            fill_cnt_next = '0;
        end else if (item.cmd == CMD_TICK && state_reg == ST_FILLING
                     && fill_cnt_reg != TIMER_MAX) begin
            fill_cnt_next = fill_cnt_reg + 1'b1;
        end
    end

    // Advance state once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INITIAL;
            fill_cnt_reg <= '0;
        end else if (step) begin
            state_reg    <= state_next;
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    assign result.mode         = mode_code(state_next);
    assign result.mode_changed = changed;
    assign result.fill_ticks   = fill_cnt_next;

endmodule

// ===== src/cryostat_autofill_controller_top.sv =====
// Channel      | Dir | Handshake              | Payload
// s_ (items)   | in  | s_tvalid / s_tready    | s_tuser: cmd; s_tdata: see port
// m_ (results) | out | m_tvalid / m_tready    | m_tdata: see port
// cfg (regs)   | in  | cfg_valid / cfg_ready  | cfg_index, cfg_wdata
//
// One item per cycle sustained while m_tready is high; items pass an input register then
// the result register, with the state machine update between them.
// s_tready follows the result register: a full result stage that is not taken
// stalls the input register, which still takes one more item while empty.
// Synchronous active-low reset clears state, fill counter, configuration registers and valids.
// cfg_ready is always high; writes take effect at the next edge.
// Depends on cafc_pkg, cafc_cfg_regs and cafc_fsm.
`timescale 1ns / 1ps

module cryostat_autofill_controller_top
    import cafc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // Input item stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [15:0] tank_temperature, [31:16] vessel_pressure, [32] autofill_on,
    // [33] supply_refilled, [39:34] zero
    input  logic [S_DATA_BITS-1:0]   s_tdata,
    // [0] cmd
    input  logic                     s_tuser,
    // Result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [2:0] mode, [3] mode_changed, [19:4] fill_ticks, [23:20] zero
    output logic [M_DATA_BITS-1:0]   m_tdata,
    // Configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t result;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_free;
    logic    step;
    logic    s_accept;

    assign cfg_ready = 1'b1;

    cafc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .cfg      (cfg)
    );

    // Handshake control
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !out_free);
    assign out_valid_next = step || (out_valid_reg && !m_tready);

    // Input register: capture each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.cmd              <= s_tuser;
            in_item_reg.tank_temperature <= s_tdata[SENSOR_BITS-1:0];
            in_item_reg.vessel_pressure  <= s_tdata[2*SENSOR_BITS-1:SENSOR_BITS];
            in_item_reg.autofill_on      <= s_tdata[2*SENSOR_BITS];
            in_item_reg.supply_refilled  <= s_tdata[2*SENSOR_BITS+1];
        end
    end

    cafc_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Result register: load when the state machine advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_BITS - M_FIELD_BITS){1'b0}},
                       out_res_reg.fill_ticks,
                       out_res_reg.mode_changed,
                       out_res_reg.mode};

endmodule

// ===== src/cafc_checker.sv =====
// Port-level checks for the cryostat autofill controller, bound to the top.
// Depends on cafc_pkg for widths and mode codes.
`timescale 1ns / 1ps

module cafc_checker
    import cafc_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_DATA_BITS-1:0] m_tdata
);

    logic [MODE_BITS-1:0]  chk_mode;
    logic                  chk_changed;
    logic [TIMER_BITS-1:0] chk_ticks;

    assign chk_mode    = m_tdata[MODE_BITS-1:0];
    assign chk_changed = m_tdata[MODE_BITS];
    assign chk_ticks   = m_tdata[MODE_BITS+TIMER_BITS:MODE_BITS+1];

    // No result is offered straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Only the six defined modes are reported
    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (chk_mode != 3'd6) && (chk_mode != 3'd7))
        else $error("undefined mode reported");

    // Entering filling starts the tick count from zero
    a_fill_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_changed && (chk_mode == MODE_FILLING) |-> chk_ticks == '0)
        else $error("fill count not cleared on entry");

endmodule

bind cryostat_autofill_controller_top cafc_checker u_cafc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
